// File: sv/lcd_pkg.sv
package lcd_pkg;

    localparam int STORE_W = 19;
    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] CTRL_NEED_BITS = 5'd6;
    localparam logic [COUNT_W-1:0] DATA_NEED_BITS = 5'd12;
    localparam logic [COUNT_W-1:0] DATA_CHAR_BITS = 5'd10;
    localparam logic [COUNT_W-1:0] CTRL_CHAR_BITS = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_CLAMP    = 5'd11;
    localparam logic [COUNT_W-1:0] BYTE_BITS      = 5'd8;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_CTRL = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_res;

    typedef struct packed {
        logic               ok;
        logic               par_ok;
        t_kind              kind;
        logic [7:0]         value;
        logic [STORE_W-1:0] store;
        logic [COUNT_W-1:0] count;
    } t_char_dec;

    // Decode the character at the front of the bit store.
    function automatic t_char_dec decode_char(input logic [STORE_W-1:0] s,
                                              input logic [COUNT_W-1:0] c);
        t_char_dec d;
        d.ok = (c >= CTRL_NEED_BITS) && (s[1] || (c >= DATA_NEED_BITS));
        if (s[1]) begin
            d.kind  = KIND_CTRL;
            d.value = {6'd0, s[3:2]};
            d.store = s >> CTRL_CHAR_BITS;
            d.count = c - CTRL_CHAR_BITS;
        end else begin
            d.kind  = KIND_DATA;
            d.value = s[9:2];
            d.store = s >> DATA_CHAR_BITS;
            d.count = c - DATA_CHAR_BITS;
        end
        d.par_ok = ^{d.value, d.store[1:0]};
        return d;
    endfunction

endpackage

// File: sv/link_character_decoder.sv
// An accepted item is registered in the input stage, then decoded into
// the result buffer that feeds the output port.
// Throughput: one item per cycle while each item yields at most one result
// and i_stall is low; an item yielding two characters holds off the next.
// Reset (synchronous, active low) empties the pipeline, clears the bit
// store and count, and clears the sticky failure.
module link_character_decoder
    import lcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_link_byte,
    input  logic       i_end_of_link,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_eol;

    logic [STORE_W-1:0] r_store, n_store;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_failed, n_failed;

    t_res               r_res [2];
    t_res               n_res [2];
    logic [1:0]         r_rem, n_rem;
    logic               r_idx;

    logic               out_take;
    logic               buf_free;
    logic               fire;
    logic               in_take;

    logic [3:0]         cnt0;
    logic [STORE_W-1:0] st0;
    logic [COUNT_W-1:0] cnt1;
    t_char_dec          d0, d1;

    assign o_valid  = (r_rem != 2'd0);
    assign out_take = o_valid && !i_stall;
    assign buf_free = (r_rem == 2'd0) || ((r_rem == 2'd1) && out_take);
    assign fire     = r_in_valid && buf_free;
    assign o_stall  = r_in_valid && !fire;
    assign in_take  = i_valid && !o_stall;

    assign o_kind  = r_res[r_idx].kind;
    assign o_value = r_res[r_idx].value;
    assign o_last  = r_res[r_idx].last;

    always_comb begin
        cnt0 = (r_count > COUNT_CLAMP) ? COUNT_CLAMP[3:0] : r_count[3:0];
        st0  = r_store | (STORE_W'(r_in_byte) << cnt0);
        cnt1 = COUNT_W'(cnt0) + BYTE_BITS;
        d0   = decode_char(st0, cnt1);
        d1   = decode_char(d0.store, d0.count);

        n_store  = r_store;
        n_count  = r_count;
        n_failed = r_failed;
        n_rem    = 2'd0;
        n_res[0] = '{kind: KIND_FAIL, value: 8'd0, last: 1'b1};
        n_res[1] = '{kind: KIND_FAIL, value: 8'd0, last: 1'b1};

        if (r_failed || r_in_eol) begin
            n_failed = 1'b1;
            n_rem    = 2'd1;
        end else if (!d0.ok) begin
            n_store = st0;
            n_count = cnt1;
        end else if (!d0.par_ok) begin
            n_failed = 1'b1;
            n_rem    = 2'd1;
        end else begin
            n_res[0] = '{kind: d0.kind, value: d0.value, last: 1'b1};
            if (!d1.ok) begin
                n_rem   = 2'd1;
                n_store = d0.store;
                n_count = d0.count;
            end else begin
                n_res[0].last = 1'b0;
                n_rem         = 2'd2;
                if (!d1.par_ok) begin
                    n_failed = 1'b1;
                end else begin
                    n_res[1] = '{kind: d1.kind, value: d1.value, last: 1'b1};
                    n_store  = d1.store;
                    n_count  = d1.count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_store    <= '0;
            r_count    <= '0;
            r_failed   <= 1'b0;
            r_rem      <= 2'd0;
            r_idx      <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_store  <= n_store;
                r_count  <= n_count;
                r_failed <= n_failed;
                r_rem    <= n_rem;
                r_idx    <= 1'b0;
            end else if (out_take) begin
                r_rem <= r_rem - 2'd1;
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_link_byte;
            r_in_eol  <= i_end_of_link;
        end
        if (fire) begin
            r_res[0] <= n_res[0];
            r_res[1] <= n_res[1];
        end
    end

endmodule
